FILE: rtl/rwlm_pkg.sv
package rwlm_pkg;

    localparam int ID_W  = 8;
    localparam int CNT_W = 9;
    localparam logic [CNT_W-1:0] READER_MAX = 9'd256;

    typedef enum logic [1:0] {
        OP_RD_LOCK   = 2'd0,
        OP_WR_LOCK   = 2'd1,
        OP_RD_UNLOCK = 2'd2,
        OP_WR_UNLOCK = 2'd3
    } op_t;

    localparam logic [2:0] EV_GRANT    = 3'd0;
    localparam logic [2:0] EV_QUEUED   = 3'd1;
    localparam logic [2:0] EV_WOKEN    = 3'd2;
    localparam logic [2:0] EV_RELEASED = 3'd3;
    localparam logic [2:0] EV_FULL     = 3'd4;
    localparam logic [2:0] EV_BAD      = 3'd5;

    // classified request handed from the front to the back
    typedef struct packed {
        logic            unlock;
        logic            writer;
        logic [ID_W-1:0] id;
    } cmd_t;

    typedef struct packed {
        logic [2:0]       ev;
        logic [ID_W-1:0]  who;
        logic             as_writer;
        logic [CNT_W-1:0] reader_total;
        logic             writer_holds;
        logic [ID_W-1:0]  owner;
        logic             owner_known;
    } result_t;

endpackage

FILE: rtl/rwlm_ram.sv
module rwlm_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/rwlm_front.sv
module rwlm_front #(
    parameter int ID_BITS = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [1:0]           in_op,
    input  logic [rwlm_pkg::ID_W-1:0] in_id,
    output logic                 cmd_valid,
    input  logic                 cmd_ready,
    output rwlm_pkg::cmd_t       cmd
);
    import rwlm_pkg::*;

    localparam int IDW = (ID_BITS < ID_W) ? ID_BITS : ID_W;
    localparam logic [ID_W-1:0] ID_MASK = ID_W'((1 << IDW) - 1);

    logic cmd_valid_reg;
    logic cmd_valid_next;
    cmd_t cmd_reg;
    cmd_t cmd_next;
    logic accept;

    assign in_ready = !cmd_valid_reg || cmd_ready;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        cmd_next    = cmd_reg;
        cmd_next.id = in_id & ID_MASK;
        unique case (op_t'(in_op))
            OP_RD_LOCK:   begin cmd_next.unlock = 1'b0; cmd_next.writer = 1'b0; end
            OP_WR_LOCK:   begin cmd_next.unlock = 1'b0; cmd_next.writer = 1'b1; end
            OP_RD_UNLOCK: begin cmd_next.unlock = 1'b1; cmd_next.writer = 1'b0; end
            OP_WR_UNLOCK: begin cmd_next.unlock = 1'b1; cmd_next.writer = 1'b1; end
            default:      begin cmd_next.unlock = 1'b0; cmd_next.writer = 1'b0; end
        endcase

        if (accept)
        begin
            cmd_valid_next = 1'b1;
        end
        else if (cmd_ready)
        begin
            cmd_valid_next = 1'b0;
        end
        else
        begin
            cmd_valid_next = cmd_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
        end
        else
        begin
            cmd_valid_reg <= cmd_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd_next;
        end
    end

    assign cmd_valid = cmd_valid_reg;
    assign cmd       = cmd_reg;

endmodule

FILE: rtl/rwlm_cmdq.sv
module rwlm_cmdq (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  rwlm_pkg::cmd_t push_cmd,
    output logic           pop_valid,
    input  logic           pop_ready,
    output rwlm_pkg::cmd_t pop_cmd
);
    import rwlm_pkg::*;

    // two-entry queue between front and back
    cmd_t       slot_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic       push;
    logic       pop;

    assign push_ready = (cnt_reg != 2'd2);
    assign pop_valid  = (cnt_reg != 2'd0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_cmd    = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        case ({push, pop})
            2'b10:   cnt_next = cnt_reg + 2'd1;
            2'b01:   cnt_next = cnt_reg - 2'd1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

FILE: rtl/rwlm_back.sv
module rwlm_back #(
    parameter int QUEUE_DEPTH = 16,
    parameter int ID_BITS     = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_ready,
    input  rwlm_pkg::cmd_t    cmd,
    output logic              out_valid,
    input  logic              out_ready,
    output rwlm_pkg::result_t out_res,
    output logic              out_last
);
    import rwlm_pkg::*;

    localparam int IDW    = (ID_BITS < ID_W) ? ID_BITS : ID_W;
    localparam int QW     = IDW + 1;
    localparam int PTR_W  = $clog2(QUEUE_DEPTH);
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W  = FILL_W + 1;
    localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(QUEUE_DEPTH);
    localparam logic [SUM_W-1:0]  SUM_DEPTH = SUM_W'(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0]  PTR_LAST  = PTR_W'(QUEUE_DEPTH - 1);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_LOAD  = 4'b0010,
        S_TAKE  = 4'b0100,
        S_FLUSH = 4'b1000
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  rc_reg, rc_next;
    logic              wf_reg, wf_next;
    logic [ID_W-1:0]   own_reg, own_next;
    logic              ov_reg, ov_next;
    logic [PTR_W-1:0]  head_reg, head_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    result_t           pend_reg, pend_next;
    logic              out_valid_reg;
    result_t           out_res_reg;
    logic              out_last_reg;

    logic              can_emit;
    logic              emit;
    logic              emit_last;
    result_t           emit_res;
    logic [2:0]        res_ev;
    logic [ID_W-1:0]   res_who;
    logic              res_wr;
    result_t           res;
    logic              we;
    logic [SUM_W-1:0]  tail_sum;
    logic [PTR_W-1:0]  tail;
    logic [QW-1:0]     rd_data;
    logic              e_wr;
    logic [ID_W-1:0]   e_id;
    logic              blocked;
    logic              ok;

    rwlm_ram #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_wait_ram (
        .clk     (clk),
        .we      (we),
        .wr_addr (tail),
        .wr_data ({cmd.writer, cmd.id[IDW-1:0]}),
        .rd_addr (head_reg),
        .rd_data (rd_data)
    );

    assign can_emit  = !out_valid_reg || out_ready;
    assign cmd_ready = (state_reg == S_IDLE) && can_emit;
    assign e_wr      = rd_data[IDW];
    assign e_id      = ID_W'(rd_data[IDW-1:0]);

    always_comb
    begin
        tail_sum = SUM_W'(head_reg) + SUM_W'(fill_reg);
        if (tail_sum >= SUM_DEPTH)
        begin
            tail = PTR_W'(tail_sum - SUM_DEPTH);
        end
        else
        begin
            tail = PTR_W'(tail_sum);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        rc_next    = rc_reg;
        wf_next    = wf_reg;
        own_next   = own_reg;
        ov_next    = ov_reg;
        head_next  = head_reg;
        fill_next  = fill_reg;
        pend_next  = pend_reg;
        emit       = 1'b0;
        emit_last  = 1'b1;
        we         = 1'b0;
        res_ev     = EV_GRANT;
        res_who    = cmd.id;
        res_wr     = cmd.writer;
        blocked    = 1'b0;
        ok         = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid && can_emit)
                begin
                    emit = 1'b1;
                    if (!cmd.unlock)
                    begin
                        if (cmd.writer)
                        begin
                            blocked = wf_reg || (rc_reg != '0);
                        end
                        else
                        begin
                            blocked = wf_reg || (rc_reg >= READER_MAX);
                        end
                        if (blocked)
                        begin
                            if (fill_reg == FILL_MAX)
                            begin
                                res_ev = EV_FULL;
                            end
                            else
                            begin
                                res_ev    = EV_QUEUED;
                                we        = 1'b1;
                                fill_next = fill_reg + 1'b1;
                            end
                        end
                        else
                        begin
                            res_ev = EV_GRANT;
                            if (cmd.writer)
                            begin
                                wf_next  = 1'b1;
                                own_next = cmd.id;
                                ov_next  = 1'b1;
                            end
                            else
                            begin
                                if (rc_reg == '0)
                                begin
                                    own_next = cmd.id;
                                    ov_next  = 1'b1;
                                end
                                rc_next = rc_reg + 1'b1;
                            end
                        end
                    end
                    else
                    begin
                        if (cmd.writer)
                        begin
                            ok = wf_reg && ov_reg && (own_reg == cmd.id);
                        end
                        else
                        begin
                            ok = (rc_reg != '0);
                        end
                        if (!ok)
                        begin
                            res_ev = EV_BAD;
                        end
                        else if (!cmd.writer && (rc_reg > CNT_W'(1)))
                        begin
                            // other readers remain; only the owner record may go
                            res_ev  = EV_RELEASED;
                            rc_next = rc_reg - 1'b1;
                            if (ov_reg && (own_reg == cmd.id))
                            begin
                                own_next = '0;
                                ov_next  = 1'b0;
                            end
                        end
                        else
                        begin
                            res_ev   = EV_RELEASED;
                            wf_next  = 1'b0;
                            rc_next  = '0;
                            own_next = '0;
                            ov_next  = 1'b0;
                            if (fill_reg != '0)
                            begin
                                // head always wakes after a last release; hold the
                                // release result until the walk settles tlast
                                emit       = 1'b0;
                                state_next = S_LOAD;
                            end
                        end
                    end
                end
            end
            S_LOAD:
            begin
                state_next = S_TAKE;
            end
            S_TAKE:
            begin
                if (can_emit)
                begin
                    emit = 1'b1;
                    if (e_wr && (rc_reg != '0))
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        emit_last = 1'b0;
                        res_ev    = EV_WOKEN;
                        res_who   = e_id;
                        res_wr    = e_wr;
                        if (e_wr)
                        begin
                            wf_next = 1'b1;
                        end
                        else
                        begin
                            rc_next = rc_reg + 1'b1;
                        end
                        head_next  = (head_reg == PTR_LAST) ? '0 : head_reg + 1'b1;
                        fill_next  = fill_reg - 1'b1;
                        own_next   = e_id;
                        ov_next    = 1'b1;
                        state_next = (e_wr || (fill_reg == FILL_W'(1))) ? S_FLUSH : S_LOAD;
                    end
                end
            end
            S_FLUSH:
            begin
                if (can_emit)
                begin
                    emit       = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        res.ev           = res_ev;
        res.who          = res_who;
        res.as_writer    = res_wr;
        res.reader_total = rc_next;
        res.writer_holds = wf_next;
        res.owner        = own_next;
        res.owner_known  = ov_next;

        // a stalled wakeup keeps the held result
        if ((state_reg == S_IDLE) || ((state_reg == S_TAKE) && can_emit))
        begin
            pend_next = res;
        end
        emit_res = (state_reg == S_IDLE) ? res : pend_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rc_reg        <= '0;
            wf_reg        <= 1'b0;
            own_reg       <= '0;
            ov_reg        <= 1'b0;
            head_reg      <= '0;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rc_reg    <= rc_next;
            wf_reg    <= wf_next;
            own_reg   <= own_next;
            ov_reg    <= ov_next;
            head_reg  <= head_next;
            fill_reg  <= fill_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
        if (emit)
        begin
            out_res_reg  <= emit_res;
            out_last_reg <= emit_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;
    assign out_last  = out_last_reg;

endmodule

FILE: rtl/reader_writer_lock_manager.sv
// channel   dir  tdata (lsb up)                                      tuser        tlast
// s_*       in   requester[7:0]                                      op[1:0]      -
// m_*       out  who[7:0] as_writer reader_total[8:0] writer_holds   event_res    last
//                owner[7:0] owner_known, pad to 32 bits              [2:0]
//
// A lock or a one-result unlock passes the front, queue and output registers to m_*.
// A last release that wakes waiters holds the back end as it walks the wait queue
// via S_LOAD and S_TAKE: each wakeup is a registered read of the wait-queue RAM.
// Reset clears the lock state and empties the wait queue at once; no sweep.
// A stalled m_tready holds the back end; the two-entry queue and the front
// register keep taking requests until they fill.
module reader_writer_lock_manager #(
    parameter int QUEUE_DEPTH = 16,
    parameter int ID_BITS     = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // requester[7:0]
    input  logic [1:0]  s_tuser,   // op[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // who, as_writer, reader_total, writer_holds, owner,
                                   // owner_known, zero pad
    output logic [2:0]  m_tuser,   // event_res[2:0]
    output logic        m_tlast
);
    import rwlm_pkg::*;

    logic    front_valid;
    logic    front_ready;
    cmd_t    front_cmd;
    logic    q_valid;
    logic    q_ready;
    cmd_t    q_cmd;
    result_t res;

    rwlm_front #(
        .ID_BITS (ID_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_op     (s_tuser),
        .in_id     (s_tdata),
        .cmd_valid (front_valid),
        .cmd_ready (front_ready),
        .cmd       (front_cmd)
    );

    rwlm_cmdq u_cmdq (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_cmd   (front_cmd),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_cmd    (q_cmd)
    );

    rwlm_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ID_BITS     (ID_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (q_valid),
        .cmd_ready (q_ready),
        .cmd       (q_cmd),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (res),
        .out_last  (m_tlast)
    );

    assign m_tuser = res.ev;
    assign m_tdata = {4'b0000, res.owner_known, res.owner, res.writer_holds,
                      res.reader_total, res.as_writer, res.who};

endmodule

FILE: rtl/rwlm_checker.sv
module rwlm_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [7:0]  s_tdata,
    input logic [1:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [2:0]  m_tuser,
    input logic        m_tlast
);
    import rwlm_pkg::*;

    logic [1:0] s_op;
    logic [7:0] s_id;

    assign s_op  = s_tuser;
    assign s_id  = s_tdata;

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("result changed while stalled");

    // readers and a writer never hold together
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[18] && (m_tdata[17:9] != 9'd0)))
        else $error("reader and writer hold at once");

    a_wr_owner: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[18] |-> m_tdata[27])
        else $error("writer holds without owner");

    // a woken waiter or a granted writer becomes the owner
    a_woken: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == EV_WOKEN || (m_tuser == EV_GRANT && m_tdata[8]))
            |-> m_tdata[27] && (m_tdata[26:19] == m_tdata[7:0]))
        else $error("owner does not match grant");

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && !s_tready |=> s_tvalid && (s_op == $past(s_op)) && (s_id == $past(s_id)))
        else $error("request changed while stalled");

endmodule

bind reader_writer_lock_manager rwlm_checker u_rwlm_checker (.*);
